@@ sv/dda_pkg.sv @@
package dda_pkg;

  localparam int MapDim     = 64;
  localparam int CellBits   = $clog2(MapDim);
  localparam int FracBits   = 16;
  localparam int SideBits   = 40;
  localparam int DeltaBits  = 32;
  localparam int PosBits    = CellBits + FracBits;
  localparam int DimBits    = 7;
  localparam int ScrBits    = 12;
  localparam int DivNumBits = ScrBits + FracBits;
  localparam int DivCntBits = $clog2(DivNumBits + 1);

  localparam logic [SideBits-1:0]  SideMax  = {SideBits{1'b1}};
  localparam logic [DeltaBits-1:0] DeltaInf = {DeltaBits{1'b1}};

  localparam logic [2:0] RegPlayerX = 3'd0;
  localparam logic [2:0] RegPlayerY = 3'd1;
  localparam logic [2:0] RegMapW    = 3'd2;
  localparam logic [2:0] RegMapH    = 3'd3;
  localparam logic [2:0] RegScreenH = 3'd4;

  localparam logic [1:0] FaceNorth = 2'd0;
  localparam logic [1:0] FaceSouth = 2'd1;
  localparam logic [1:0] FaceWest  = 2'd2;
  localparam logic [1:0] FaceEast  = 2'd3;

  // Divider control between the sequencer and the serial divider
  typedef struct packed {
    logic                  start;
    logic [DivNumBits-1:0] num;
    logic [DeltaBits-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DivNumBits-1:0] quo;
  } div_rsp_t;

endpackage

@@ sv/dda_div.sv @@
module dda_div (
  input  logic              clk,
  input  logic              rst,
  input  dda_pkg::div_req_t req,
  output dda_pkg::div_rsp_t rsp
);
  import dda_pkg::*;

  logic                  run;
  logic                  done_q;
  logic [DivCntBits-1:0] cnt;
  logic [DivNumBits-1:0] num;
  logic [DivNumBits-1:0] quo;
  logic [DeltaBits-1:0]  den;
  logic [DeltaBits:0]    rem;
  logic [DeltaBits:0]    trial;
  logic                  fits;

  // Shift in one numerator bit and try one subtract per cycle
  assign trial = {rem[DeltaBits-1:0], num[DivNumBits-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= DivCntBits'(DivNumBits);
        num <= req.num;
        den <= req.den;
        rem <= '0;
        quo <= '0;
      end else if (run) begin
        rem <= fits ? trial - {1'b0, den} : trial;
        quo <= {quo[DivNumBits-2:0], fits};
        num <= {num[DivNumBits-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == DivCntBits'(1)) begin
          run    <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_q, quo: quo};

endmodule

@@ sv/dda_grid_ray_caster.sv @@
// Cell write: accepted while idle, no result; the next item may follow at once.
// Cast: set-up of the x then y side lengths (INITX, INITY), then DDA steps (step,
// then map test), then the 28-bit serial divide, then one output state that
// strobes done with the result.
// busy is high while a cast runs and drops in the strobe cycle; the receiver cannot stall.
// Synchronous reset returns config to 0/0/64/64/480; the map is not cleared.
module dda_grid_ray_caster (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        cell_is_wall,
  input  logic        dir_x_neg,
  input  logic        dir_y_neg,
  input  logic [31:0] grid_len_x,
  input  logic [31:0] grid_len_y,
  output logic        done,
  output logic [1:0]  wall_face,
  output logic        hit_side,
  output logic        out_of_bounds,
  output logic [31:0] wall_dist,
  output logic [15:0] wall_rows,
  output logic signed [15:0] row_top,
  output logic [15:0] row_bottom
);
  import dda_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INITX = 7'b0000010,
    S_INITY = 7'b0000100,
    S_STEP = 7'b0001000,
    S_TEST = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  logic [PosBits-1:0]  player_x, player_y;
  logic [DimBits-1:0]  map_width, map_height;
  logic [ScrBits-1:0]  screen_height;

  logic                neg_x, neg_y;
  logic [DeltaBits-1:0] dx, dy;
  logic [DimBits:0]    walk_cell_x, walk_cell_y;
  logic [SideBits-1:0] side_len_x, side_len_y;
  logic                last_axis;
  logic                oob;
  logic [DeltaBits-1:0] perp;
  logic                map_bit;
  logic [DimBits-1:0]  lim_w, lim_h;

  logic                wall_map [MapDim*MapDim];

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Shared Q16 multiplier for the initial side lengths
  logic                 mul_sel_y;
  logic [FracBits-1:0]  mul_frac;
  logic                 mul_neg;
  logic [DeltaBits-1:0] mul_d;
  logic [FracBits:0]    span;
  logic [FracBits+DeltaBits:0] prod;
  logic [SideBits-1:0]  init_side;

  assign mul_sel_y = (state == S_INITY);
  assign mul_frac  = mul_sel_y ? player_y[FracBits-1:0] : player_x[FracBits-1:0];
  assign mul_neg   = mul_sel_y ? neg_y : neg_x;
  assign mul_d     = mul_sel_y ? dy : dx;
  assign span      = mul_neg ? {1'b0, mul_frac} : (FracBits+1)'(1 << FracBits)
                                                 - {1'b0, mul_frac};
  assign prod      = span * mul_d;
  assign init_side = (mul_d == DeltaInf) ? SideMax : SideBits'(prod >> FracBits);

  // Shared saturating adder and compare for the walk
  logic                  step_x;
  logic [SideBits-1:0]   add_a;
  logic [DeltaBits-1:0]  add_d;
  logic [SideBits:0]     add_sum;
  logic [SideBits-1:0]   add_sat;

  assign step_x  = side_len_x < side_len_y;
  assign add_a   = step_x ? side_len_x : side_len_y;
  assign add_d   = step_x ? dx : dy;
  assign add_sum = {1'b0, add_a} + (SideBits+1)'(add_d);
  assign add_sat = (add_d == DeltaInf || add_sum > {1'b0, SideMax}) ? SideMax
                                                                     : add_sum[SideBits-1:0];

  assign lim_w = (map_width > DimBits'(MapDim)) ? DimBits'(MapDim) : map_width;
  assign lim_h = (map_height > DimBits'(MapDim)) ? DimBits'(MapDim) : map_height;

  // Perpendicular distance from the last stepped axis
  logic [SideBits-1:0]  fin_side;
  logic [DeltaBits-1:0] fin_d;
  logic [SideBits-1:0]  fin_diff;
  logic [DeltaBits-1:0] perp_next;

  assign fin_side  = last_axis ? side_len_y : side_len_x;
  assign fin_d     = last_axis ? dy : dx;
  assign fin_diff  = fin_side - SideBits'(fin_d);
  assign perp_next = (fin_side >= SideMax) ? DeltaInf :
                     (fin_side < SideBits'(fin_d)) ? '0 :
                     (fin_diff > SideBits'(DeltaInf)) ? DeltaInf : fin_diff[DeltaBits-1:0];

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= '0;
      player_y      <= '0;
      map_width     <= DimBits'(64);
      map_height    <= DimBits'(64);
      screen_height <= ScrBits'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPlayerX: player_x      <= cfg_data[PosBits-1:0];
        RegPlayerY: player_y      <= cfg_data[PosBits-1:0];
        RegMapW:    map_width     <= cfg_data[DimBits-1:0];
        RegMapH:    map_height    <= cfg_data[DimBits-1:0];
        RegScreenH: screen_height <= cfg_data[ScrBits-1:0];
        default: ;
      endcase
    end
  end

  // Address the cell that the current step moves into
  logic [DimBits:0] rd_cell_x, rd_cell_y;
  assign rd_cell_x = (state == S_STEP && step_x) ?
                     (neg_x ? walk_cell_x - 1'b1 : walk_cell_x + 1'b1) : walk_cell_x;
  assign rd_cell_y = (state == S_STEP && !step_x) ?
                     (neg_y ? walk_cell_y - 1'b1 : walk_cell_y + 1'b1) : walk_cell_y;

  // Map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (start && !busy && !req_type)
      wall_map[{cell_y, cell_x}] <= cell_is_wall;
    map_bit <= wall_map[{rd_cell_y[CellBits-1:0], rd_cell_x[CellBits-1:0]}];
  end

  logic in_map;
  assign in_map = !walk_cell_x[DimBits] && !walk_cell_y[DimBits] &&
                  walk_cell_x[DimBits-1:0] < lim_w && walk_cell_y[DimBits-1:0] < lim_h;

  logic [ScrBits+FracBits-1:0] quo_full;
  logic [15:0] lh;
  assign quo_full = div_rsp.quo;
  assign lh = (quo_full > 65535) ? 16'hFFFF : quo_full[15:0];

  // Sequence one cast
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      walk_cell_x <= '0;
      walk_cell_y <= '0;
      side_len_x  <= '0;
      side_len_y  <= '0;
      last_axis   <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      done          <= 1'b0;
      div_req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && req_type) begin
            neg_x <= dir_x_neg;
            neg_y <= dir_y_neg;
            dx    <= grid_len_x;
            dy    <= grid_len_y;
            walk_cell_x <= (DimBits+1)'(player_x[PosBits-1:FracBits]);
            walk_cell_y <= (DimBits+1)'(player_y[PosBits-1:FracBits]);
            state <= S_INITX;
          end
        end
        S_INITX: begin
          side_len_x <= init_side;
          state <= S_INITY;
        end
        S_INITY: begin
          side_len_y <= init_side;
          state <= S_STEP;
        end
        S_STEP: begin
          if (step_x) begin
            side_len_x  <= add_sat;
            walk_cell_x <= neg_x ? walk_cell_x - 1'b1 : walk_cell_x + 1'b1;
            last_axis   <= 1'b0;
          end else begin
            side_len_y  <= add_sat;
            walk_cell_y <= neg_y ? walk_cell_y - 1'b1 : walk_cell_y + 1'b1;
            last_axis   <= 1'b1;
          end
          state <= S_TEST;
        end
        S_TEST: begin
          if (!in_map || map_bit) begin
            oob <= !in_map;
            if (!in_map)        wall_face <= FaceNorth;
            else if (!last_axis) wall_face <= neg_x ? FaceEast : FaceWest;
            else                 wall_face <= neg_y ? FaceSouth : FaceNorth;
            perp <= perp_next;
            div_req.start <= 1'b1;
            div_req.num   <= {screen_height, FracBits'(0)};
            div_req.den   <= perp_next;
            state <= S_DIV;
          end else begin
            state <= S_STEP;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the wall height in rows when the divide finishes
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_rsp.done) begin
      wall_rows <= (screen_height == '0) ? 16'd0 : (perp == '0) ? 16'hFFFF : lh;
    end
  end

  logic [15:0] half;
  assign half = 16'(screen_height >> 1);

  assign busy          = (state != S_IDLE);
  assign hit_side      = last_axis;
  assign out_of_bounds = oob;
  assign wall_dist     = perp;
  assign row_top       = $signed(half - (wall_rows >> 1));
  assign row_bottom    = half + (wall_rows >> 1);

  dda_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // A result only follows a divide
  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_OUT)) else $error("result without divide");
  // busy is low whenever the sequencer is idle
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy) else $error("busy while idle");
  // Every walk step is followed by a map test
  a_step_test: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |=> (state == S_TEST)) else $error("step not followed by test");

endmodule

@@ test/tb_dda_grid_ray_caster.sv @@
`timescale 1ns / 1ps

module tb_dda_grid_ray_caster;
  import dda_pkg::*;

  typedef struct packed {
    logic [1:0]  face;
    logic        side;
    logic        oob;
    logic [31:0] perp;
    logic [15:0] height;
    logic [15:0] first_row;
    logic [15:0] last_row;
  } column_t;

  localparam int WatchdogLimit = 4000;
  // Casts stay inside this square corner of the map, but for one directed view
  localparam int MapUsed = 14;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = RegPlayerX;
  logic [21:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic req_type = 1'b0;
  logic [5:0] cell_x = '0;
  logic [5:0] cell_y = '0;
  logic cell_is_wall = 1'b0;
  logic dir_x_neg = 1'b0;
  logic dir_y_neg = 1'b0;
  logic [31:0] grid_len_x = '0;
  logic [31:0] grid_len_y = '0;
  logic done;
  logic [1:0] wall_face;
  logic hit_side;
  logic out_of_bounds;
  logic [31:0] wall_dist;
  logic [15:0] wall_rows;
  logic signed [15:0] row_top;
  logic [15:0] row_bottom;

  dda_grid_ray_caster dut (.*);

  always #4 clk = ~clk;

  // Predictor state and register copies
  bit wall_bits [MapDim*MapDim];
  logic [21:0] pos_x = '0, pos_y = '0;
  logic [6:0] cols = 7'd64, rows = 7'd64;
  logic [11:0] scr_h = 12'd480;

  column_t columns_due[$];
  int errors = 0;
  int stall_cycles = 0;
  bit allow_idle = 1'b1;

  function automatic logic [39:0] first_side(logic [21:0] pos, logic neg, logic [31:0] d);
    logic [16:0] span;
    span = neg ? {1'b0, pos[15:0]} : (17'h10000 - {1'b0, pos[15:0]});
    if (d == DeltaInf) return SideMax;
    return 40'((64'(span) * 64'(d)) >> FracBits);
  endfunction

  function automatic logic [39:0] side_step(logic [39:0] s, logic [31:0] d);
    logic [40:0] r;
    if (d == DeltaInf) return SideMax;
    r = {1'b0, s} + 41'(d);
    return r > 41'(SideMax) ? SideMax : r[39:0];
  endfunction

  function automatic column_t cast_column(logic nx, logic ny, logic [31:0] dx, logic [31:0] dy);
    column_t c;
    int cx, cy, w, h;
    logic [39:0] sx, sy, s, d;
    logic [31:0] lh;
    logic [63:0] q;
    logic [15:0] half;
    logic axis;
    w = cols > MapDim ? MapDim : cols;
    h = rows > MapDim ? MapDim : rows;
    cx = pos_x >> FracBits;
    cy = pos_y >> FracBits;
    sx = first_side(pos_x, nx, dx);
    sy = first_side(pos_y, ny, dy);
    c = '0;
    forever begin
      // step across the nearer grid line, y on a tie
      if (sx < sy) begin
        sx = side_step(sx, dx);
        cx += nx ? -1 : 1;
        axis = 1'b0;
      end else begin
        sy = side_step(sy, dy);
        cy += ny ? -1 : 1;
        axis = 1'b1;
      end
      if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
        c.oob = 1'b1;
        c.face = FaceNorth;
        break;
      end
      if (wall_bits[cy*MapDim + cx]) begin
        if (!axis) c.face = nx ? FaceEast : FaceWest;
        else c.face = ny ? FaceSouth : FaceNorth;
        break;
      end
    end
    c.side = axis;
    s = axis ? sy : sx;
    d = axis ? 40'(dy) : 40'(dx);
    if (s >= SideMax) c.perp = '1;
    else if (s < d) c.perp = '0;
    else c.perp = (s - d) > 40'hFFFFFFFF ? '1 : 32'(s - d);
    if (c.perp == 0) lh = scr_h != 0 ? 65535 : 0;
    else begin
      q = (64'(scr_h) << FracBits) / 64'(c.perp);
      lh = q > 65535 ? 65535 : 32'(q);
    end
    half = 16'(scr_h / 2);
    c.height = 16'(lh);
    c.first_row = half - 16'(lh / 2);
    c.last_row = half + 16'(lh / 2);
    return c;
  endfunction

  // Check each result against the oldest expectation; run the watchdog
  always @(posedge clk) begin
    column_t want, got;
    if (!rst) begin
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (done) begin
        got = '{wall_face, hit_side, out_of_bounds, wall_dist, wall_rows,
                row_top, row_bottom};
        if (columns_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = columns_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: face %0d/%0d side %0d/%0d oob %0d/%0d perp %h/%h",
                       want.face, got.face, want.side, got.side, want.oob, got.oob,
                       want.perp, got.perp, " height %0d/%0d rows %0d..%0d / %0d..%0d",
                       want.height, got.height, $signed(want.first_row),
                       $signed(want.last_row), $signed(got.first_row),
                       $signed(got.last_row));
          end
        end
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic idle_burst();
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
  endtask

  // Present one item and hold it until accepted, then update the predictor
  task automatic send_item(logic kind, logic [5:0] x, logic [5:0] y, logic wall,
                           logic nx, logic ny, logic [31:0] dx, logic [31:0] dy);
    idle_burst();
    @(negedge clk);
    start <= 1'b1;
    req_type <= kind;
    cell_x <= x;
    cell_y <= y;
    cell_is_wall <= wall;
    dir_x_neg <= nx;
    dir_y_neg <= ny;
    grid_len_x <= dx;
    grid_len_y <= dy;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (kind) columns_due.push_back(cast_column(nx, ny, dx, dy));
    else wall_bits[{y, x}] = wall;
  endtask

  task automatic write_cell(int x, int y, bit wall);
    send_item(1'b0, 6'(x), 6'(y), wall, 1'($urandom), 1'($urandom), $urandom, $urandom);
  endtask

  task automatic cast(logic nx, logic ny, logic [31:0] dx, logic [31:0] dy);
    send_item(1'b1, 6'($urandom), 6'($urandom), 1'($urandom), nx, ny, dx, dy);
  endtask

  // Hold off until every expected result is in and a cell write has settled
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (columns_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 22'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegPlayerX: pos_x = 22'(value);
      RegPlayerY: pos_y = 22'(value);
      RegMapW:    cols = 7'(value);
      RegMapH:    rows = 7'(value);
      RegScreenH: scr_h = 12'(value);
      default: ;
    endcase
  endtask

  task automatic set_view(int px, int py, int w, int h, int sh);
    drain();
    write_reg(RegPlayerX, px);
    write_reg(RegPlayerY, py);
    write_reg(RegMapW, w);
    write_reg(RegMapH, h);
    write_reg(RegScreenH, sh);
  endtask

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 11))
      0: return DeltaInf;
      1: return 32'd0;
      2, 3: return $urandom;
      default: return $urandom_range(32'h1000, 32'h100000);
    endcase
  endfunction

  function automatic int pick_pos(int cells);
    return $urandom_range(0, cells * 65536 - 1);
  endfunction

  // Fill every cell of the used corner so no cast inside it reads an unwritten one
  task automatic test_map_load();
    for (int y = 0; y < MapUsed; y++)
      for (int x = 0; x < MapUsed; x++)
        write_cell(x, y, $urandom_range(0, 7) == 0);
  endtask

  task automatic test_directed();
    set_view(7 * 65536 + 16'h8000, 7 * 65536 + 16'h8000, MapUsed, MapUsed, 480);
    for (int i = 0; i < 4; i++) cast(i[0], i[1], 32'h10000, 32'h18000);
    cast(1'b0, 1'b0, 32'h10000, 32'h10000);
    cast(1'b1, 1'b0, DeltaInf, 32'h20000);
    cast(1'b0, 1'b1, 32'h20000, DeltaInf);
    cast(1'b0, 1'b0, DeltaInf, DeltaInf);
    cast(1'b1, 1'b1, 32'd0, 32'd0);
    cast(1'b0, 1'b1, 32'hFFFFFFFE, 32'hFFFFFFFE);
    cast(1'b1, 1'b0, 32'd0, 32'h10000);
    // empty path out of the map: clear two cells, then cast out of a one-cell map
    write_cell(8, 7, 1'b0);
    write_cell(9, 7, 1'b0);
    set_view(0, 0, 1, 1, 0);
    cast(1'b0, 1'b0, 32'h10000, 32'h10000);
    cast(1'b1, 1'b1, 32'h10000, 32'h20000);
    set_view(22'h3FFFFF, 22'h3FFFFF, 127, 0, 4095);
    cast(1'b1, 1'b1, 32'h8000, 32'h9000);
    cast(1'b0, 1'b0, 32'h8000, 32'h9000);
    set_view(10 * 65536, 5 * 65536 + 16'hFFFF, MapUsed, MapUsed, 2048);
    cast(1'b1, 1'b0, 32'h4000, 32'h400);
    cast(1'b0, 1'b1, 32'h100, 32'h80000);
    cast(1'b1, 1'b1, 32'h1, 32'h1);
  endtask

  task automatic random_casts(int n);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 4) == 0) write_cell($urandom_range(0, 63),
                                                $urandom_range(0, 63),
                                                $urandom_range(0, 5) == 0);
      else cast(1'($urandom), 1'($urandom), pick_delta(), pick_delta());
  endtask

  task automatic test_view_sweep();
    int w, h;
    for (int k = 0; k < 8; k++) begin
      w = $urandom_range(1, MapUsed);
      h = $urandom_range(1, MapUsed);
      set_view(pick_pos(w), pick_pos(h), w, h, $urandom_range(0, 4095));
      random_casts(30);
    end
  endtask

  task automatic test_pause_until_empty();
    set_view(pick_pos(MapUsed), pick_pos(MapUsed), MapUsed, MapUsed, 480);
    random_casts(20);
    drain();
    random_casts(20);
  endtask

  task automatic test_back_to_back();
    allow_idle = 1'b0;
    set_view(pick_pos(MapUsed), pick_pos(MapUsed), MapUsed, MapUsed,
             $urandom_range(1, 2048));
    random_casts(60);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_map_load();
    test_directed();
    test_view_sweep();
    test_pause_until_empty();
    test_back_to_back();
    drain();
    repeat (40) @(negedge clk);
    errors += columns_due.size();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/dda_pkg.sv
sv/dda_div.sv
sv/dda_grid_ray_caster.sv
test/tb_dda_grid_ray_caster.sv
